/* rtl/pcm_pkg.sv */
// ---------------------------------------------------------------------------
// pcm_pkg
// Shared widths, reset values, register codes and control types for the
// path curvature monitor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcm_pkg;

  localparam int COORD_W  = 32;
  localparam int MAG_W    = 32;
  localparam int SQ_W     = 2 * MAG_W + 1;
  localparam int RAD_W    = SQ_W + 1;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int SQ_STEPS = ROOT_W;
  localparam int LANES    = 3;
  localparam int PPROD_W  = 2 * MAG_W;
  localparam int CROSS_W  = PPROD_W + 1;
  localparam int PROD_W   = 2 * ROOT_W;
  localparam int NUM_W    = CROSS_W + 33;
  localparam int DEN_W    = 3 * ROOT_W;
  localparam int CURV_W   = 26;
  localparam int MINLEN_W = 21;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [MINLEN_W-1:0] MIN_SIDE_RESET = 21'd1311;
  localparam logic [CURV_W-1:0]   ALLOWED_RESET  = 26'd94208;
  localparam logic [CURV_W-1:0]   CURV_MAX       = '1;

  typedef enum logic {
    REG_MIN_SIDE = 1'b0,
    REG_ALLOWED  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic live;
    logic has_triple;
    logic start;
  } beat_ctl_t;

endpackage

/* rtl/pcm_sqrt.sv */
// ---------------------------------------------------------------------------
// pcm_sqrt
// Pipelined restoring integer square root, one result bit per stage, for
// three side lengths side by side, with a sideband carried alongside.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_sqrt #(
  parameter int SB_W = 1
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic [pcm_pkg::LANES-1:0][pcm_pkg::RAD_W-1:0]  rad,
  input  logic [SB_W-1:0]                          sb_in,
  output logic [pcm_pkg::LANES-1:0][pcm_pkg::ROOT_W-1:0] root_out,
  output logic [SB_W-1:0]                          sb_out
);
  import pcm_pkg::*;

  logic [LANES-1:0][RAD_W-1:0]  rad_s  [SQ_STEPS+1];
  logic [LANES-1:0][REM_W-1:0]  rem_s  [SQ_STEPS+1];
  logic [LANES-1:0][ROOT_W-1:0] root_s [SQ_STEPS+1];
  logic [SB_W-1:0]              sb_s   [SQ_STEPS+1];

  assign rad_s[0]  = rad;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign sb_s[0]   = sb_in;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    localparam int I = SQ_STEPS - 1 - k;
    logic [LANES-1:0][REM_W-1:0]  rem_next;
    logic [LANES-1:0][ROOT_W-1:0] root_next;

    always_comb begin
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        rem_sh = {rem_s[k][l][REM_W-3:0], rad_s[k][l][2*I+1 -: 2]};
        trial  = REM_W'({root_s[k][l], 2'b01});
        if (rem_sh >= trial) begin
          rem_next[l]  = rem_sh - trial;
          root_next[l] = {root_s[k][l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_next[l]  = rem_sh;
          root_next[l] = {root_s[k][l][ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k+1]  <= rad_s[k];
        rem_s[k+1]  <= rem_next;
        root_s[k+1] <= root_next;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sb_s[k+1] <= '0;
      end else if (en) begin
        sb_s[k+1] <= sb_s[k];
      end
    end
  end

  assign root_out = root_s[SQ_STEPS];
  assign sb_out   = sb_s[SQ_STEPS];

endmodule

/* rtl/pcm_div.sv */
// ---------------------------------------------------------------------------
// pcm_div
// Pipelined restoring divider: saturation check, then one quotient bit per
// stage. Forced-zero and saturated cases resolve at the last stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_div #(
  parameter int SB_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [pcm_pkg::NUM_W-1:0]     num,
  input  logic [pcm_pkg::DEN_W-1:0]     den,
  input  logic                          force_zero,
  input  logic [SB_W-1:0]               sb_in,
  output logic [pcm_pkg::CURV_W-1:0]    quo,
  output logic [SB_W-1:0]               sb_out
);
  import pcm_pkg::*;

  localparam int STEPS = CURV_W;

  logic [NUM_W-1:0]  num_s  [STEPS+1];
  logic [DEN_W-1:0]  den_s  [STEPS+1];
  logic [CURV_W-1:0] q_s    [STEPS+1];
  logic              zero_s [STEPS+1];
  logic              sat_s  [STEPS+1];
  logic [SB_W-1:0]   sb_s   [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      num_s[0]  <= num;
      den_s[0]  <= den;
      q_s[0]    <= '0;
      zero_s[0] <= force_zero;
      sat_s[0]  <= DEN_W'(num >> CURV_W) >= den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_s[0] <= '0;
    end else if (en) begin
      sb_s[0] <= sb_in;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int I = STEPS - 1 - k;
    logic take;

    assign take = DEN_W'(num_s[k] >> I) >= den_s[k];

    always_ff @(posedge clk) begin
      if (en) begin
        num_s[k+1]  <= take ? num_s[k] - (NUM_W'(den_s[k]) << I) : num_s[k];
        den_s[k+1]  <= den_s[k];
        q_s[k+1]    <= take ? (q_s[k] | (CURV_W'(1) << I)) : q_s[k];
        zero_s[k+1] <= zero_s[k];
        sat_s[k+1]  <= sat_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sb_s[k+1] <= '0;
      end else if (en) begin
        sb_s[k+1] <= sb_s[k];
      end
    end
  end

  assign quo    = zero_s[STEPS] ? '0 : (sat_s[STEPS] ? CURV_MAX : q_s[STEPS]);
  assign sb_out = sb_s[STEPS];

endmodule

/* rtl/path_curvature_monitor.sv */
// Throughput: one sample per cycle; a stalled output freezes the whole pipe.
// The depth comes from the 33-stage square root and the 27-stage divider.
// Reset: synchronous; clears history, sample count, peak, stage control bits,
// result_valid and sets the registers to their defaults.
// ---------------------------------------------------------------------------
// path_curvature_monitor
// Three-point Menger curvature of a planar sample stream with running peak
// and over-bound flag, APB-style register port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_curvature_monitor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [pcm_pkg::COORD_W-1:0] pos_x,
  input  logic signed [pcm_pkg::COORD_W-1:0] pos_y,
  input  logic                               path_start,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [pcm_pkg::CURV_W-1:0]         curvature,
  output logic                               curvature_valid,
  output logic [pcm_pkg::CURV_W-1:0]         peak_curvature,
  output logic                               over_bound,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pcm_pkg::ADDR_W-1:0]         paddr,
  input  logic [pcm_pkg::DATA_W-1:0]         pwdata,
  output logic [pcm_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import pcm_pkg::*;

  localparam int SQ_SB_W = $bits(beat_ctl_t) + 1 + 2 * PPROD_W;

  logic en;
  logic [MINLEN_W-1:0] min_side_length;
  logic [CURV_W-1:0]   curv_bound;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_side_length <= MIN_SIDE_RESET;
      curv_bound      <= ALLOWED_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_MIN_SIDE: min_side_length <= pwdata[MINLEN_W-1:0];
        REG_ALLOWED:  curv_bound      <= pwdata[CURV_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_MIN_SIDE: prdata = DATA_W'(min_side_length);
      REG_ALLOWED:  prdata = DATA_W'(curv_bound);
    endcase
  end

  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // history
  logic [COORD_W-1:0] older_x, older_y, middle_x, middle_y;
  logic [1:0]         samples_seen;
  logic [1:0]         seen_eff;

  assign seen_eff = path_start ? 2'd0 : samples_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      older_x      <= '0;
      older_y      <= '0;
      middle_x     <= '0;
      middle_y     <= '0;
      samples_seen <= '0;
    end else if (en && sample_valid) begin
      older_x      <= middle_x;
      older_y      <= middle_y;
      middle_x     <= pos_x;
      middle_y     <= pos_y;
      samples_seen <= (seen_eff < 2'd2) ? seen_eff + 2'd1 : seen_eff;
    end
  end

  // differences
  logic signed [COORD_W:0] d1x, d1y, d2x, d2y, d3x, d3y;

  assign d1x = {middle_x[COORD_W-1], middle_x} - {older_x[COORD_W-1], older_x};
  assign d1y = {middle_y[COORD_W-1], middle_y} - {older_y[COORD_W-1], older_y};
  assign d2x = {pos_x[COORD_W-1], pos_x} - {middle_x[COORD_W-1], middle_x};
  assign d2y = {pos_y[COORD_W-1], pos_y} - {middle_y[COORD_W-1], middle_y};
  assign d3x = {pos_x[COORD_W-1], pos_x} - {older_x[COORD_W-1], older_x};
  assign d3y = {pos_y[COORD_W-1], pos_y} - {older_y[COORD_W-1], older_y};

  // stage 1
  beat_ctl_t        ctl1;
  logic [MAG_W-1:0] m1x, m1y, m2x, m2y, m3x, m3y;
  logic             s1x, s1y, s2x, s2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (en) begin
      ctl1.live       <= sample_valid;
      ctl1.has_triple <= seen_eff == 2'd2;
      ctl1.start      <= path_start;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1x <= d1x[COORD_W] ? MAG_W'(-d1x) : MAG_W'(d1x);
      m1y <= d1y[COORD_W] ? MAG_W'(-d1y) : MAG_W'(d1y);
      m2x <= d2x[COORD_W] ? MAG_W'(-d2x) : MAG_W'(d2x);
      m2y <= d2y[COORD_W] ? MAG_W'(-d2y) : MAG_W'(d2y);
      m3x <= d3x[COORD_W] ? MAG_W'(-d3x) : MAG_W'(d3x);
      m3y <= d3y[COORD_W] ? MAG_W'(-d3y) : MAG_W'(d3y);
      s1x <= d1x[COORD_W];
      s1y <= d1y[COORD_W];
      s2x <= d2x[COORD_W];
      s2y <= d2y[COORD_W];
    end
  end

  // stage 2: squares and cross terms
  beat_ctl_t          ctl2;
  logic [SQ_W-1:0]    sq1, sq2, sq3;
  logic [PPROD_W-1:0] pp, rr;
  logic               same2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (en) begin
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1   <= SQ_W'(PPROD_W'(m1x) * PPROD_W'(m1x)) + SQ_W'(PPROD_W'(m1y) * PPROD_W'(m1y));
      sq2   <= SQ_W'(PPROD_W'(m2x) * PPROD_W'(m2x)) + SQ_W'(PPROD_W'(m2y) * PPROD_W'(m2y));
      sq3   <= SQ_W'(PPROD_W'(m3x) * PPROD_W'(m3x)) + SQ_W'(PPROD_W'(m3y) * PPROD_W'(m3y));
      pp    <= PPROD_W'(m1x) * PPROD_W'(m2y);
      rr    <= PPROD_W'(m1y) * PPROD_W'(m2x);
      same2 <= (s1x ^ s2y) == (s1y ^ s2x);
    end
  end

  // side lengths
  logic [LANES-1:0][RAD_W-1:0]  rad;
  logic [LANES-1:0][ROOT_W-1:0] roots;
  logic [SQ_SB_W-1:0]           sq_sb_out;
  beat_ctl_t                    ctl35;
  logic                         same35;
  logic [PPROD_W-1:0]           pp35, rr35;

  assign rad[0] = RAD_W'(sq1);
  assign rad[1] = RAD_W'(sq2);
  assign rad[2] = RAD_W'(sq3);

  pcm_sqrt #(
    .SB_W (SQ_SB_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rad      (rad),
    .sb_in    ({ctl2, same2, pp, rr}),
    .root_out (roots),
    .sb_out   (sq_sb_out)
  );

  assign {ctl35, same35, pp35, rr35} = sq_sb_out;

  // stage 36: side check, first length product, cross magnitude
  beat_ctl_t          ctl36;
  logic               zero36;
  logic [PROD_W-1:0]  prod_ab;
  logic [ROOT_W-1:0]  lc36;
  logic [CROSS_W-1:0] cross36;
  logic               short_side;

  always_comb begin
    short_side = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (roots[l] < ROOT_W'(min_side_length) || roots[l] == '0) begin
        short_side = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl36 <= '0;
    end else if (en) begin
      ctl36 <= ctl35;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero36  <= !ctl35.has_triple || short_side;
      prod_ab <= PROD_W'(roots[0]) * PROD_W'(roots[1]);
      lc36    <= roots[2];
      if (!same35) begin
        cross36 <= CROSS_W'(pp35) + CROSS_W'(rr35);
      end else if (pp35 >= rr35) begin
        cross36 <= CROSS_W'(pp35 - rr35);
      end else begin
        cross36 <= CROSS_W'(rr35 - pp35);
      end
    end
  end

  // stage 37: partial products of the third length
  beat_ctl_t          ctl37;
  logic               zero37;
  logic [PROD_W-1:0]  part_lo, part_hi;
  logic [CROSS_W-1:0] cross37;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl37 <= '0;
    end else if (en) begin
      ctl37 <= ctl36;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero37  <= zero36;
      part_lo <= PROD_W'(prod_ab[ROOT_W-1:0]) * PROD_W'(lc36);
      part_hi <= PROD_W'(prod_ab[PROD_W-1:ROOT_W]) * PROD_W'(lc36);
      cross37 <= cross36;
    end
  end

  // stage 38: denominator
  beat_ctl_t          ctl38;
  logic               zero38;
  logic [DEN_W-1:0]   den38;
  logic [CROSS_W-1:0] cross38;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl38 <= '0;
    end else if (en) begin
      ctl38 <= ctl37;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero38  <= zero37;
      den38   <= DEN_W'(part_lo) + (DEN_W'(part_hi) << ROOT_W);
      cross38 <= cross37;
    end
  end

  // divide
  logic [CURV_W-1:0] quo;
  beat_ctl_t         ctl65;

  pcm_div #(
    .SB_W ($bits(beat_ctl_t))
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .num        ({cross38, {(NUM_W - CROSS_W){1'b0}}}),
    .den        (den38),
    .force_zero (zero38),
    .sb_in      (ctl38),
    .quo        (quo),
    .sb_out     (ctl65)
  );

  // peak tracking and output register
  logic [CURV_W-1:0] peak_value;
  logic [CURV_W-1:0] peak_base;
  logic [CURV_W-1:0] peak_next;

  assign peak_base = ctl65.start ? '0 : peak_value;
  assign peak_next = (ctl65.has_triple && quo > peak_base) ? quo : peak_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value   <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= ctl65.live;
      if (ctl65.live) begin
        peak_value <= peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl65.live) begin
      curvature       <= quo;
      curvature_valid <= ctl65.has_triple;
      peak_curvature  <= peak_next;
      over_bound      <= peak_next > curv_bound;
    end
  end

endmodule

/* rtl/pcm_checker.sv */
// ---------------------------------------------------------------------------
// pcm_checker
// Port-level checks for the path curvature monitor, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       sample_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [pcm_pkg::CURV_W-1:0] curvature,
  input logic                       curvature_valid,
  input logic [pcm_pkg::CURV_W-1:0] peak_curvature,
  input logic                       over_bound
);
  import pcm_pkg::*;

  // held beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(peak_curvature)
      && $stable(curvature))
    else $error("stalled result beat changed");

  a_no_triple: assert property (@(posedge clk) disable iff (rst)
    result_valid && !curvature_valid |-> curvature == '0)
    else $error("curvature without a triple");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    result_valid && curvature_valid |-> peak_curvature >= curvature)
    else $error("peak below current curvature");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && over_bound |-> peak_curvature != '0)
    else $error("over-bound with zero peak");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("input stalled while output free");

endmodule

bind path_curvature_monitor pcm_checker u_pcm_checker (
  .clk             (clk),
  .rst             (rst),
  .sample_stall    (sample_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .curvature       (curvature),
  .curvature_valid (curvature_valid),
  .peak_curvature  (peak_curvature),
  .over_bound      (over_bound)
);
